// ===== rtl/hcaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hcaf_pkg;

  localparam int unsigned ActW  = 5;
  localparam int unsigned DataW = 8;
  localparam int unsigned BitW  = 3;

  // operation codes
  localparam logic [ActW-1:0] OP_ADD    = 5'd0;
  localparam logic [ActW-1:0] OP_ADC    = 5'd1;
  localparam logic [ActW-1:0] OP_SUB    = 5'd2;
  localparam logic [ActW-1:0] OP_SBC    = 5'd3;
  localparam logic [ActW-1:0] OP_AND    = 5'd4;
  localparam logic [ActW-1:0] OP_XOR    = 5'd5;
  localparam logic [ActW-1:0] OP_OR     = 5'd6;
  localparam logic [ActW-1:0] OP_CP     = 5'd7;
  localparam logic [ActW-1:0] OP_DAA    = 5'd8;
  localparam logic [ActW-1:0] OP_CPL    = 5'd9;
  localparam logic [ActW-1:0] OP_SCF    = 5'd10;
  localparam logic [ActW-1:0] OP_CCF    = 5'd11;
  localparam logic [ActW-1:0] OP_RLCA   = 5'd12;
  localparam logic [ActW-1:0] OP_RLA    = 5'd13;
  localparam logic [ActW-1:0] OP_RRCA   = 5'd14;
  localparam logic [ActW-1:0] OP_RRA    = 5'd15;
  localparam logic [ActW-1:0] OP_INC    = 5'd16;
  localparam logic [ActW-1:0] OP_DEC    = 5'd17;
  localparam logic [ActW-1:0] OP_RLC    = 5'd18;
  localparam logic [ActW-1:0] OP_RRC    = 5'd19;
  localparam logic [ActW-1:0] OP_RL     = 5'd20;
  localparam logic [ActW-1:0] OP_RR     = 5'd21;
  localparam logic [ActW-1:0] OP_SLA    = 5'd22;
  localparam logic [ActW-1:0] OP_SRA    = 5'd23;
  localparam logic [ActW-1:0] OP_SWAP   = 5'd24;
  localparam logic [ActW-1:0] OP_SRL    = 5'd25;
  localparam logic [ActW-1:0] OP_BIT    = 5'd26;
  localparam logic [ActW-1:0] OP_RES    = 5'd27;
  localparam logic [ActW-1:0] OP_SET    = 5'd28;
  localparam logic [ActW-1:0] OP_LOAD_A = 5'd29;

  // decimal adjust constants
  localparam logic [DataW-1:0] DAA_HI   = 8'h60;
  localparam logic [DataW-1:0] DAA_LO   = 8'h06;
  localparam logic [DataW-1:0] BCD_MAX  = 8'h99;
  localparam logic [3:0]       NIB_MAX  = 4'h9;
  localparam logic [3:0]       NIB_FULL = 4'hF;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [DataW-1:0] acc;
    logic [DataW-1:0] res;
    flags_t           flags;
  } alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/hcaf_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hcaf_in_if;
  logic                              valid;
  logic                              ready;
  logic [hcaf_pkg::ActW-1:0]         action;
  logic [hcaf_pkg::DataW-1:0]        operand;
  logic [hcaf_pkg::BitW-1:0]         bit_index;

  modport source (output valid, output action, output operand, output bit_index,
                  input ready);
  modport sink (input valid, input action, input operand, input bit_index,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/hcaf_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface hcaf_out_if;
  logic                       valid;
  logic                       ready;
  logic [hcaf_pkg::DataW-1:0] accumulator_out;
  logic [hcaf_pkg::DataW-1:0] result_value;
  logic                       zero_flag;
  logic                       subtract_flag;
  logic                       half_carry_flag;
  logic                       carry_flag;

  modport source (output valid, output accumulator_out, output result_value,
                  output zero_flag, output subtract_flag, output half_carry_flag,
                  output carry_flag, input ready);
  modport sink (input valid, input accumulator_out, input result_value,
                input zero_flag, input subtract_flag, input half_carry_flag,
                input carry_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/hcaf_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcaf_alu (
  input  wire logic [hcaf_pkg::DataW-1:0] acc,
  input  wire hcaf_pkg::flags_t           flags,
  input  wire logic [hcaf_pkg::ActW-1:0]  action,
  input  wire logic [hcaf_pkg::DataW-1:0] operand,
  input  wire logic [hcaf_pkg::BitW-1:0]  bit_index,
  output hcaf_pkg::alu_res_t              result
);

  always_comb begin
    logic [hcaf_pkg::DataW-1:0] a;
    logic [hcaf_pkg::DataW-1:0] b;
    logic [hcaf_pkg::DataW-1:0] res;
    logic [hcaf_pkg::DataW-1:0] adj;
    logic [hcaf_pkg::DataW-1:0] mask;
    logic [hcaf_pkg::DataW:0]   sum9;
    logic [hcaf_pkg::DataW:0]   sub_rhs;
    logic [4:0]                 nib5;
    logic [4:0]                 nib_rhs;
    logic                       cin;
    hcaf_pkg::flags_t           f;

    a    = acc;
    b    = operand;
    res  = acc;
    f    = flags;
    cin  = 1'b0;
    adj  = '0;
    sum9 = '0;
    nib5 = '0;
    mask = 8'b1 << bit_index;
    sub_rhs = '0;
    nib_rhs = '0;

    case (action)
      hcaf_pkg::OP_ADD, hcaf_pkg::OP_ADC: begin
        cin  = (action == hcaf_pkg::OP_ADC) && flags.c;
        sum9 = {1'b0, a} + {1'b0, b} + {8'b0, cin};
        nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
        f.h  = nib5[4];
        f.c  = sum9[8];
        a    = sum9[7:0];
        res  = a;
        f.z  = (a == 8'h00);
        f.n  = 1'b0;
      end
      hcaf_pkg::OP_SUB, hcaf_pkg::OP_SBC, hcaf_pkg::OP_CP: begin
        cin     = (action == hcaf_pkg::OP_SBC) && flags.c;
        nib_rhs = {1'b0, b[3:0]} + {4'b0, cin};
        sub_rhs = {1'b0, b} + {8'b0, cin};
        f.h     = {1'b0, a[3:0]} < nib_rhs;
        f.c     = {1'b0, a} < sub_rhs;
        res     = a - b - {7'b0, cin};
        f.z     = (res == 8'h00);
        f.n     = 1'b1;
        if (action != hcaf_pkg::OP_CP) begin
          a = res;
        end
      end
      hcaf_pkg::OP_AND: begin
        a = a & b; res = a;
        f = '{z: (a == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      hcaf_pkg::OP_XOR: begin
        a = a ^ b; res = a;
        f = '{z: (a == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      hcaf_pkg::OP_OR: begin
        a = a | b; res = a;
        f = '{z: (a == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      hcaf_pkg::OP_DAA: begin
        if (flags.c) adj = adj | hcaf_pkg::DAA_HI;
        if (flags.h) adj = adj | hcaf_pkg::DAA_LO;
        if (!flags.n) begin
          if (a[3:0] > hcaf_pkg::NIB_MAX) adj = adj | hcaf_pkg::DAA_LO;
          if (a > hcaf_pkg::BCD_MAX)      adj = adj | hcaf_pkg::DAA_HI;
          a = a + adj;
        end else begin
          a = a - adj;
        end
        f.c = flags.c || (adj >= hcaf_pkg::DAA_HI);
        f.z = (a == 8'h00);
        f.h = 1'b0;
        res = a;
      end
      hcaf_pkg::OP_CPL: begin
        a = ~a; res = a; f.h = 1'b1; f.n = 1'b1;
      end
      hcaf_pkg::OP_SCF: begin
        f.h = 1'b0; f.n = 1'b0; f.c = 1'b1;
      end
      hcaf_pkg::OP_CCF: begin
        f.h = 1'b0; f.n = 1'b0; f.c = !flags.c;
      end
      hcaf_pkg::OP_RLCA: begin
        f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
        a = {acc[6:0], acc[7]}; res = a;
      end
      hcaf_pkg::OP_RLA: begin
        f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
        a = {acc[6:0], flags.c}; res = a;
      end
      hcaf_pkg::OP_RRCA: begin
        f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
        a = {acc[0], acc[7:1]}; res = a;
      end
      hcaf_pkg::OP_RRA: begin
        f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
        a = {flags.c, acc[7:1]}; res = a;
      end
      hcaf_pkg::OP_INC: begin
        f.h = (b[3:0] == hcaf_pkg::NIB_FULL);
        res = b + 8'd1;
        f.z = (res == 8'h00);
        f.n = 1'b0;
      end
      hcaf_pkg::OP_DEC: begin
        f.h = (b[3:0] == 4'h0);
        res = b - 8'd1;
        f.z = (res == 8'h00);
        f.n = 1'b1;
      end
      hcaf_pkg::OP_RLC, hcaf_pkg::OP_RRC, hcaf_pkg::OP_RL, hcaf_pkg::OP_RR,
      hcaf_pkg::OP_SLA, hcaf_pkg::OP_SRA, hcaf_pkg::OP_SWAP, hcaf_pkg::OP_SRL: begin
        case (action)
          hcaf_pkg::OP_RLC:  begin res = {b[6:0], b[7]};    f.c = b[7]; end
          hcaf_pkg::OP_RRC:  begin res = {b[0], b[7:1]};    f.c = b[0]; end
          hcaf_pkg::OP_RL:   begin res = {b[6:0], flags.c}; f.c = b[7]; end
          hcaf_pkg::OP_RR:   begin res = {flags.c, b[7:1]}; f.c = b[0]; end
          hcaf_pkg::OP_SLA:  begin res = {b[6:0], 1'b0};    f.c = b[7]; end
          hcaf_pkg::OP_SRA:  begin res = {b[7], b[7:1]};    f.c = b[0]; end
          hcaf_pkg::OP_SWAP: begin res = {b[3:0], b[7:4]};  f.c = 1'b0; end
          default:           begin res = {1'b0, b[7:1]};    f.c = b[0]; end
        endcase
        f.z = (res == 8'h00);
        f.n = 1'b0;
        f.h = 1'b0;
      end
      hcaf_pkg::OP_BIT: begin
        f.z = ((b & mask) == 8'h00);
        f.h = 1'b1;
        f.n = 1'b0;
        res = b;
      end
      hcaf_pkg::OP_RES:    res = b & ~mask;
      hcaf_pkg::OP_SET:    res = b | mask;
      hcaf_pkg::OP_LOAD_A: begin a = b; res = b; end
      // unused codes leave everything as it is
      default: ;
    endcase

    result.acc   = a;
    result.res   = res;
    result.flags = f;
  end

endmodule

`default_nettype wire

// ===== rtl/handheld_cpu_alu_flags_top.sv =====
// 8-bit accumulator ALU with Z, N, H and C flags. Each transfer on in_ch carries an
// operation code, an operand byte and a bit index; each produces exactly one transfer
// on out_ch with the new accumulator, the byte produced and the four flags. An item
// goes through an input register and then an output register, from which out_ch is
// driven; throughput is one item per cycle while out_ch does not stall, since the
// accumulator and flag registers are updated in the same cycle the item leaves the
// input register and the next item reads them in the following cycle. A stalled
// output holds its result while one more item waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module handheld_cpu_alu_flags_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  hcaf_in_if.sink         in_ch,
  hcaf_out_if.source      out_ch
);

  logic                       s1_valid_r, s1_valid_nxt;
  logic [hcaf_pkg::ActW-1:0]  s1_action_r;
  logic [hcaf_pkg::DataW-1:0] s1_operand_r;
  logic [hcaf_pkg::BitW-1:0]  s1_bit_index_r;

  logic [hcaf_pkg::DataW-1:0] acc_r;
  hcaf_pkg::flags_t           flags_r;

  logic                       out_valid_r, out_valid_nxt;
  hcaf_pkg::alu_res_t         out_data_r;

  hcaf_pkg::alu_res_t         alu_res;
  logic                       out_free;
  logic                       s1_adv;
  logic                       in_xfer;

  hcaf_alu u_alu (
    .acc       (acc_r),
    .flags     (flags_r),
    .action    (s1_action_r),
    .operand   (s1_operand_r),
    .bit_index (s1_bit_index_r),
    .result    (alu_res)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // architectural state moves with the item into the output register
      if (s1_adv) begin
        acc_r   <= alu_res.acc;
        flags_r <= alu_res.flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_action_r    <= in_ch.action;
      s1_operand_r   <= in_ch.operand;
      s1_bit_index_r <= in_ch.bit_index;
    end
    if (s1_adv) begin
      out_data_r <= alu_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.accumulator_out = out_data_r.acc;
  assign out_ch.result_value    = out_data_r.res;
  assign out_ch.zero_flag       = out_data_r.flags.z;
  assign out_ch.subtract_flag   = out_data_r.flags.n;
  assign out_ch.half_carry_flag = out_data_r.flags.h;
  assign out_ch.carry_flag      = out_data_r.flags.c;

endmodule

`default_nettype wire
